// ----- rtl/gimc_pkg.sv -----
// gimc_pkg: shared types, GF(16) multiply and minor index tables for the
// involutory MDS checker. No dependencies.
package gimc_pkg;

  // One GF(16) element, polynomial x^4 + x + 1
  typedef logic [3:0] gf_t;

  // Matrix as [row][col]; 2x2 minors as [row pair][col pair]
  typedef gf_t [3:0][3:0] mat_t;
  typedef gf_t [5:0][5:0] minor2_t;

  localparam int NumMinors2 = 36;
  localparam int NumMinors3 = 16;
  localparam int NumMinors  = NumMinors2 + NumMinors3;
  localparam int NumGroups  = 4;
  localparam int GroupSize  = NumMinors / NumGroups;

  localparam logic [6:0] GF_POLY = 7'h13;

  // Pipeline stage enables, one per register stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } gimc_en_t;

  // Row or column triples for 3x3 minors; each one leaves out one index
  localparam logic [1:0] TRI [0:3][0:2] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd1, 2'd3},
    '{2'd0, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3}
  };

  // Pair p covers (PAIR_LO[p], PAIR_HI[p])
  localparam logic [1:0] PAIR_LO [0:5] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_HI [0:5] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // Carry-less multiply then reduce modulo x^4 + x + 1
  function automatic gf_t gf_mul(gf_t a, gf_t b);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ (7'({3'b000, a}) << i);
    end
    for (int i = 6; i >= 4; i--) begin
      if (p[i]) p = p ^ (GF_POLY << (i - 4));
    end
    return p[3:0];
  endfunction

  // Index of the pair (a, b), a < b
  function automatic logic [2:0] pair_idx(logic [1:0] a, logic [1:0] b);
    logic [2:0] idx;
    unique case ({a, b})
      4'b0001: idx = 3'd0;
      4'b0010: idx = 3'd1;
      4'b0011: idx = 3'd2;
      4'b0110: idx = 3'd3;
      4'b0111: idx = 3'd4;
      4'b1011: idx = 3'd5;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/gf16_involutory_mds_check.sv -----
// gf16_involutory_mds_check: top level; four-stage pipeline for the
// involutory MDS test of a 4x4 GF(16) matrix. Depends on gimc_pkg,
// gimc_prod, gimc_det3 and gimc_count.
//
// Takes one matrix (four packed rows) per beat and returns one verdict per
// beat, one matrix per clock sustained while out_ready is held high. Stage 1
// forms the 2x2 minors and the square, stage 2 the 3x3 minors and zero
// flags, stage 3 group counts, stage 4 the result register, which drives
// out_valid. Each stage holds only while the stage after it is full
// and stalled, so bubbles close up under backpressure and in_ready is high
// whenever the result register is empty. in_ready depends combinationally
// on out_ready.
module gf16_involutory_mds_check import gimc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_row0,
  input  logic [15:0] in_row1,
  input  logic [15:0] in_row2,
  input  logic [15:0] in_row3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_minors_nonzero,
  output logic        out_is_involution,
  output logic        out_accepted,
  output logic [5:0]  out_zero_minor_count
);

  gimc_en_t en;
  logic     v1_r, v2_r, v3_r, v4_r;
  logic     v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  mat_t     mat1;
  minor2_t  minor2_1;
  logic     invol1, invol2;
  logic [NumMinors-1:0] zflag2;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    en.s4 = !v4_r || out_ready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_ready  = en.s1;
  assign out_valid = v4_r;

  // Valid bits follow the data
  always_comb begin
    v1_nxt = en.s1 ? in_valid : v1_r;
    v2_nxt = en.s2 ? v1_r     : v2_r;
    v3_nxt = en.s3 ? v2_r     : v3_r;
    v4_nxt = en.s4 ? v3_r     : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  gimc_prod u_prod (
    .clk      (clk),
    .en       (en),
    .row0     (in_row0),
    .row1     (in_row1),
    .row2     (in_row2),
    .row3     (in_row3),
    .mat_r    (mat1),
    .minor2_r (minor2_1),
    .invol_r  (invol1)
  );

  gimc_det3 u_det3 (
    .clk     (clk),
    .en      (en),
    .mat     (mat1),
    .minor2  (minor2_1),
    .invol   (invol1),
    .zflag_r (zflag2),
    .invol_r (invol2)
  );

  gimc_count u_count (
    .clk                (clk),
    .en                 (en),
    .zflag              (zflag2),
    .invol              (invol2),
    .minors_nonzero_r   (out_minors_nonzero),
    .is_involution_r    (out_is_involution),
    .accepted_r         (out_accepted),
    .zero_minor_count_r (out_zero_minor_count)
  );

endmodule

// ----- rtl/gimc_prod.sv -----
// gimc_prod: first stage; unpacks the matrix, forms all 36 2x2 minors and
// tests the square against the identity. Depends on gimc_pkg.
module gimc_prod import gimc_pkg::*; (
  input  logic     clk,
  input  gimc_en_t en,
  input  logic [15:0] row0,
  input  logic [15:0] row1,
  input  logic [15:0] row2,
  input  logic [15:0] row3,
  output mat_t     mat_r,
  output minor2_t  minor2_r,
  output logic     invol_r
);

  mat_t    mat;
  minor2_t minor2_nxt;
  logic    invol_nxt;

  // Unpack rows, column 0 in the low nibble
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mat[0][c] = row0[4*c +: 4];
      mat[1][c] = row1[4*c +: 4];
      mat[2][c] = row2[4*c +: 4];
      mat[3][c] = row3[4*c +: 4];
    end
  end

  // 2x2 minors over every row pair and column pair
  always_comb begin
    for (int p = 0; p < 6; p++) begin
      for (int q = 0; q < 6; q++) begin
        minor2_nxt[p][q] =
          gf_mul(mat[PAIR_LO[p]][PAIR_LO[q]], mat[PAIR_HI[p]][PAIR_HI[q]]) ^
          gf_mul(mat[PAIR_HI[p]][PAIR_LO[q]], mat[PAIR_LO[p]][PAIR_HI[q]]);
      end
    end
  end

  // M*M compared with the identity
  always_comb begin
    gf_t s;
    invol_nxt = 1'b1;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s = '0;
        for (int k = 0; k < 4; k++) begin
          s = s ^ gf_mul(mat[i][k], mat[k][j]);
        end
        if (s != ((i == j) ? gf_t'(1) : gf_t'(0))) invol_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mat_r    <= mat;
      minor2_r <= minor2_nxt;
      invol_r  <= invol_nxt;
    end
  end

endmodule

// ----- rtl/gimc_det3.sv -----
// gimc_det3: second stage; 3x3 minors by cofactor expansion over the
// stored 2x2 minors, and a zero flag for each of the 52 minors.
// Depends on gimc_pkg.
module gimc_det3 import gimc_pkg::*; (
  input  logic     clk,
  input  gimc_en_t en,
  input  mat_t     mat,
  input  minor2_t  minor2,
  input  logic     invol,
  output logic [NumMinors-1:0] zflag_r,
  output logic     invol_r
);

  logic [NumMinors-1:0] zflag_nxt;

  always_comb begin
    logic [1:0] t0;
    logic [2:0] lp;
    logic [1:0] c0, c1, c2;
    gf_t        d;
    // 2x2 minors: zero flags only
    for (int p = 0; p < 6; p++) begin
      for (int q = 0; q < 6; q++) begin
        zflag_nxt[p*6 + q] = (minor2[p][q] == '0);
      end
    end
    // 3x3 minors: expand along the first selected row; the cofactors are
    // 2x2 minors of the remaining two rows
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        t0 = TRI[i][0];
        lp = pair_idx(TRI[i][1], TRI[i][2]);
        c0 = TRI[j][0];
        c1 = TRI[j][1];
        c2 = TRI[j][2];
        d = gf_mul(mat[t0][c0], minor2[lp][pair_idx(c1, c2)]) ^
            gf_mul(mat[t0][c1], minor2[lp][pair_idx(c0, c2)]) ^
            gf_mul(mat[t0][c2], minor2[lp][pair_idx(c0, c1)]);
        zflag_nxt[NumMinors2 + i*4 + j] = (d == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      zflag_r <= zflag_nxt;
      invol_r <= invol;
    end
  end

endmodule

// ----- rtl/gimc_count.sv -----
// gimc_count: third and fourth stages; counts zero minors in four groups,
// then sums them into the result register. Depends on gimc_pkg.
module gimc_count import gimc_pkg::*; (
  input  logic     clk,
  input  gimc_en_t en,
  input  logic [NumMinors-1:0] zflag,
  input  logic     invol,
  output logic     minors_nonzero_r,
  output logic     is_involution_r,
  output logic     accepted_r,
  output logic [5:0] zero_minor_count_r
);

  logic [3:0] grp_r   [NumGroups];
  logic [3:0] grp_nxt [NumGroups];
  logic       invol3_r;
  logic [5:0] sum_nxt;

  // Stage 3: group popcounts
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        grp_nxt[g] = grp_nxt[g] + 4'(zflag[g*GroupSize + k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      grp_r    <= grp_nxt;
      invol3_r <= invol;
    end
  end

  // Stage 4: final sum and verdict
  assign sum_nxt = 6'(grp_r[0]) + 6'(grp_r[1]) + 6'(grp_r[2]) + 6'(grp_r[3]);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      zero_minor_count_r <= sum_nxt;
      minors_nonzero_r   <= (sum_nxt == '0);
      is_involution_r    <= invol3_r;
      accepted_r         <= (sum_nxt == '0) && invol3_r;
    end
  end

endmodule

// ----- rtl/gimc_check.sv -----
// gimc_check: port-level assertions for gf16_involutory_mds_check, and the
// bind that attaches them. Depends on the top level's port list only.
module gimc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_row0,
  input logic [15:0] in_row1,
  input logic [15:0] in_row2,
  input logic [15:0] in_row3,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_minors_nonzero,
  input logic        out_is_involution,
  input logic        out_accepted,
  input logic [5:0]  out_zero_minor_count
);

  // Verdict is the AND of the two checks
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_minors_nonzero && out_is_involution)))
    else $error("accepted flag disagrees with the two checks");

  // Clean-minor flag matches a zero count
  a_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minors_nonzero == (out_zero_minor_count == 6'd0)))
    else $error("minor flag disagrees with zero count");

  // Count never exceeds the number of minors
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero_minor_count <= 6'd52))
    else $error("zero minor count out of range");

  // An empty result register never blocks the input
  a_noblock: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_zero_minor_count)
      && $stable(out_is_involution) && $stable(out_accepted))
    else $error("stalled result changed");

endmodule

bind gf16_involutory_mds_check gimc_check u_check (.*);
